// File: rtl/core/rca_pkg.sv
// rca_pkg: shared types and constants of the rank contribution accumulator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

  localparam int RANK_W    = 48;
  localparam int PAGE_W    = 16;
  localparam int DEG_W     = 5;
  localparam int N_W       = 17;
  localparam int TOTAL_W   = 17;
  localparam int DIV_W     = 34;
  localparam int DCNT_W    = 6;
  localparam int SPLIT     = 24;
  localparam int PROD_W    = TOTAL_W + SPLIT;
  localparam int SUM_W     = RANK_W + TOTAL_W + 1;
  localparam int WORD_W    = RANK_W + 1;
  localparam int QDEPTH    = 2;

  localparam logic [RANK_W-1:0]  RANK_MAX  = {RANK_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [N_W-1:0]     N_RESET   = 17'h10000;
  localparam logic [N_W-1:0]     N_MIN     = 17'd2;
  localparam logic [DCNT_W-1:0]  DIV_LAST  = 6'd47;

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_DANGLE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_EDGE,
    CMD_DANGLE,
    CMD_READ
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_MUL,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PAGE_W-1:0] page_index;
    logic [DEG_W-1:0]  out_degree;
    logic [PAGE_W-1:0] target_page;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] read_page;
    logic [RANK_W-1:0] rank_value;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              oob;
    logic [PAGE_W-1:0] page;
    logic [DEG_W-1:0]  degree;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic empty;
    logic full;
    cmd_t head;
  } q_status_t;

endpackage

`default_nettype wire

// File: rtl/core/rca_ram.sv
// rca_ram: generic single port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module rca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/rca_div.sv
// rca_div: radix-2 restoring divider of the fixed point one by a divisor
// depends on rca_pkg
`timescale 1ns / 1ps
`default_nettype none

module rca_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rca_pkg::DIV_W-1:0]   divisor,
  output logic                             done,
  output logic      [rca_pkg::RANK_W-1:0]  quotient
);

  localparam int DW = rca_pkg::DIV_W;
  localparam int RW = rca_pkg::RANK_W;

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [rca_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DW-1:0]               rem_r, rem_nxt;
  logic [DW-1:0]               dsr_r, dsr_nxt;
  logic [RW-1:0]               quo_r, quo_nxt;
  logic [DW:0]                 trial;
  logic                        fits;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, (cnt_r == '0)};
    fits     = trial >= {1'b0, dsr_r};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = fits ? DW'(trial - {1'b0, dsr_r}) : DW'(trial);
      quo_nxt = {quo_r[RW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rca_pkg::DIV_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/core/rca_queue.sv
// rca_queue: short command queue between front and back
// depends on rca_pkg
`timescale 1ns / 1ps
`default_nettype none

module rca_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rca_pkg::q_push_t   push,
  input  wire logic               pop,
  output rca_pkg::q_status_t      status
);

  localparam int D  = rca_pkg::QDEPTH;
  localparam int PW = $clog2(D);

  rca_pkg::cmd_t  slot_r [D];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    do_push = push.valid && (cnt_r != (PW+1)'(D));
    do_pop  = pop && (cnt_r != '0);
    wr_nxt  = do_push ? ((wr_r == PW'(D-1)) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == PW'(D-1)) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_r] <= push.cmd;
    end
  end

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == (PW+1)'(D));
  assign status.head  = slot_r[rd_r];

endmodule

`default_nettype wire

// File: rtl/core/rca_front.sv
// rca_front: request intake, classification and queue push
// depends on rca_pkg
`timescale 1ns / 1ps
`default_nettype none

module rca_front #(
  parameter int PAGES = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire rca_pkg::in_item_t   in_item,
  input  wire logic                clearing,
  input  wire logic                q_full,
  output logic                     busy,
  output rca_pkg::q_push_t         push
);

  logic               valid_r, valid_nxt;
  rca_pkg::in_item_t  item_r;
  logic               accept;
  logic               drop;
  logic               page_oob;
  logic               target_oob;

  always_comb begin
    page_oob   = 32'(item_r.page_index) >= PAGES;
    target_oob = 32'(item_r.target_page) >= PAGES;
    push.cmd.oob    = page_oob;
    push.cmd.degree = item_r.out_degree;
    push.cmd.page   = item_r.page_index;
    push.cmd.kind   = rca_pkg::CMD_READ;
    drop = 1'b0;
    case (item_r.opcode)
      rca_pkg::OP_EDGE: begin
        push.cmd.kind = rca_pkg::CMD_EDGE;
        push.cmd.page = item_r.target_page;
        push.cmd.oob  = target_oob;
        drop = target_oob || (item_r.out_degree == '0);
      end
      rca_pkg::OP_DANGLE: begin
        push.cmd.kind = rca_pkg::CMD_DANGLE;
        drop = page_oob;
      end
      rca_pkg::OP_READ: begin
        push.cmd.kind = rca_pkg::CMD_READ;
      end
      default: begin
        drop = 1'b1;
      end
    endcase
    push.valid = valid_r && !drop && !q_full;
    busy       = clearing || (valid_r && q_full);
    accept     = start && !busy;
    valid_nxt  = accept ? 1'b1 : (valid_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rca_back.sv
// rca_back: rank store sequencer, clearing pass, share division and read sum
// depends on rca_pkg, rca_div, rca_ram
`timescale 1ns / 1ps
`default_nettype none

module rca_back #(
  parameter int PAGES = 65536
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [rca_pkg::N_W-1:0]    page_count,
  input  wire rca_pkg::q_status_t         q_status,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            out_valid,
  output rca_pkg::out_item_t              out_result
);

  localparam int AW = $clog2(PAGES);
  localparam int DW = rca_pkg::DIV_W;
  localparam int RW = rca_pkg::RANK_W;
  localparam int WW = rca_pkg::WORD_W;
  localparam int PW = rca_pkg::PROD_W;
  localparam int SW = rca_pkg::SUM_W;
  localparam int SP = rca_pkg::SPLIT;

  rca_pkg::state_t                state_r, state_nxt;
  logic [AW-1:0]                  clr_r, clr_nxt;
  rca_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [WW-1:0]                  word_r, word_nxt;
  logic [rca_pkg::TOTAL_W-1:0]    total_r, total_nxt;
  logic [rca_pkg::TOTAL_W-1:0]    others_r, others_nxt;
  logic [RW-1:0]                  share_r, share_nxt;
  logic [PW-1:0]                  lo_r, lo_nxt;
  logic [PW-1:0]                  hi_r, hi_nxt;
  logic                           out_valid_r, out_valid_nxt;
  rca_pkg::out_item_t             out_r, out_nxt;

  logic [rca_pkg::N_W-1:0]        n;
  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [WW-1:0]                  ram_wdata;
  logic [WW-1:0]                  ram_rdata;
  logic                           div_start;
  logic [DW-1:0]                  divisor;
  logic                           div_done;
  logic [RW-1:0]                  quotient;
  logic [RW:0]                    edge_sum;
  logic [SW-1:0]                  read_sum;

  rca_ram #(
    .WIDTH (WW),
    .DEPTH (PAGES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  rca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // pages in use, clamped to at least two and at most the store
  always_comb begin
    if (page_count < rca_pkg::N_MIN) begin
      n = rca_pkg::N_MIN;
    end else if (32'(page_count) > PAGES) begin
      n = rca_pkg::N_W'(PAGES);
    end else begin
      n = page_count;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rca_pkg::ST_CLEAR: begin
        if (clr_r == AW'(PAGES - 1)) state_nxt = rca_pkg::ST_IDLE;
      end
      rca_pkg::ST_IDLE: begin
        if (!q_status.empty) state_nxt = rca_pkg::ST_LOOK;
      end
      rca_pkg::ST_LOOK: begin
        case (cmd_r.kind)
          rca_pkg::CMD_EDGE: state_nxt = rca_pkg::ST_DIV;
          rca_pkg::CMD_READ: state_nxt = cmd_r.oob ? rca_pkg::ST_IDLE : rca_pkg::ST_DIV;
          default:           state_nxt = rca_pkg::ST_IDLE;
        endcase
      end
      rca_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = (cmd_r.kind == rca_pkg::CMD_READ) ? rca_pkg::ST_MUL : rca_pkg::ST_IDLE;
        end
      end
      rca_pkg::ST_MUL: state_nxt = rca_pkg::ST_SUM;
      rca_pkg::ST_SUM: state_nxt = rca_pkg::ST_IDLE;
      default:         state_nxt = rca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    word_nxt      = word_r;
    total_nxt     = total_r;
    others_nxt    = others_r;
    share_nxt     = share_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_addr      = AW'(cmd_r.page);
    ram_wdata     = word_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    divisor       = (cmd_r.kind == rca_pkg::CMD_EDGE)
                  ? DW'(n) * DW'(cmd_r.degree)
                  : DW'(n) * DW'(n - 1'b1);
    edge_sum      = {1'b0, word_r[RW-1:0]} + {1'b0, quotient};
    read_sum      = SW'(lo_r) + (SW'(hi_r) << SP) + SW'(word_r[RW-1:0]);
    case (state_r)
      rca_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      rca_pkg::ST_IDLE: begin
        ram_addr = AW'(q_status.head.page);
        if (!q_status.empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_status.head;
        end
      end
      rca_pkg::ST_LOOK: begin
        word_nxt   = ram_rdata;
        others_nxt = total_r - rca_pkg::TOTAL_W'(ram_rdata[RW] && (total_r != '0));
        case (cmd_r.kind)
          rca_pkg::CMD_EDGE: begin
            div_start = 1'b1;
          end
          rca_pkg::CMD_DANGLE: begin
            if (!ram_rdata[RW]) begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, ram_rdata[RW-1:0]};
              if (total_r != rca_pkg::TOTAL_MAX) total_nxt = total_r + 1'b1;
            end
          end
          rca_pkg::CMD_READ: begin
            if (cmd_r.oob) begin
              out_valid_nxt      = 1'b1;
              out_nxt.read_page  = cmd_r.page;
              out_nxt.rank_value = '0;
            end else begin
              div_start = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      rca_pkg::ST_DIV: begin
        if (div_done) begin
          share_nxt = quotient;
          if (cmd_r.kind == rca_pkg::CMD_EDGE) begin
            ram_we    = 1'b1;
            ram_wdata = {word_r[RW], edge_sum[RW] ? rca_pkg::RANK_MAX : edge_sum[RW-1:0]};
          end
        end
      end
      rca_pkg::ST_MUL: begin
        lo_nxt = PW'(others_r) * PW'(share_r[SP-1:0]);
        hi_nxt = PW'(others_r) * PW'(share_r[RW-1:SP]);
      end
      rca_pkg::ST_SUM: begin
        out_valid_nxt      = 1'b1;
        out_nxt.read_page  = cmd_r.page;
        out_nxt.rank_value = (read_sum > SW'(rca_pkg::RANK_MAX))
                           ? rca_pkg::RANK_MAX : read_sum[RW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rca_pkg::ST_CLEAR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    word_r   <= word_nxt;
    others_r <= others_nxt;
    share_r  <= share_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    out_r    <= out_nxt;
  end

  assign clearing   = (state_r == rca_pkg::ST_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == rca_pkg::ST_SUM || $past(state_r) == rca_pkg::ST_LOOK))
    else $error("result strobe without a finished read");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rca_pkg::ST_CLEAR |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != rca_pkg::ST_CLEAR) |-> cmd_r.kind != rca_pkg::CMD_READ)
    else $error("rank store written by a read");

  a_div_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rca_pkg::ST_DIV && div_done) |=> state_r != rca_pkg::ST_DIV)
    else $error("sequencer stuck after division");

endmodule

`default_nettype wire

// File: rtl/core/rank_contribution_accumulator_core.sv
// rank_contribution_accumulator_core: top level of the rank accumulator
// depends on rca_pkg, rca_front, rca_queue, rca_back
//
//   channel   ports                         handshake
//   in        start, busy, in_item          taken when start and not busy
//   out       out_valid, out_result         one cycle strobe, no back-pressure
//   cfg       cfg_we, cfg_data              written when cfg_we
//
// edge request: the back end waits on the 48 step share divider
// dangling request: one lookup and a marking write; read request: divider then split multiply
// after reset busy stays high while the rank store is cleared
// a two entry queue lets the front take requests while the back end divides
`timescale 1ns / 1ps
`default_nettype none

module rank_contribution_accumulator_core #(
  parameter int PAGES = 65536
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rca_pkg::in_item_t           in_item,
  output logic                             out_valid,
  output rca_pkg::out_item_t               out_result,
  input  wire logic                        cfg_we,
  input  wire logic [rca_pkg::N_W-1:0]     cfg_data
);

  logic [rca_pkg::N_W-1:0] page_count_r, page_count_nxt;
  rca_pkg::q_push_t        push;
  rca_pkg::q_status_t      q_status;
  logic                    q_pop;
  logic                    clearing;

  assign page_count_nxt = cfg_we ? cfg_data : page_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= rca_pkg::N_RESET;
    end else begin
      page_count_r <= page_count_nxt;
    end
  end

  rca_front #(
    .PAGES (PAGES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .clearing (clearing),
    .q_full   (q_status.full),
    .busy     (busy),
    .push     (push)
  );

  rca_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (q_pop),
    .status (q_status)
  );

  rca_back #(
    .PAGES (PAGES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .page_count (page_count_r),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
